// ===== rtl/core/sle_pkg.sv =====
// ---------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sorted list engine: command, status and
// per-cell operation codes, plus the control bundle broadcast to the cells.
// ---------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LengthW = 5;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // command codes carried in the input word
  typedef enum logic [CmdW-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_PREPEND = 3'd1,
    CMD_APPEND  = 3'd2,
    CMD_REMOVE  = 3'd3,
    CMD_SEARCH  = 3'd4
  } cmd_e;

  // status codes returned in the output word
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // what every cell does at the next edge
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_PREPEND,
    OP_APPEND,
    OP_REMOVE
  } cell_op_e;

  // control bundle broadcast to the whole row
  typedef struct packed {
    cell_op_e                 op;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sorted_list_engine_core.sv =====
// ---------------------------------------------------------------------------
// sorted_list_engine_core
// Ordered list of signed 32-bit values kept in a row of compare-and-shift
// cells, driven by a stream of insert, prepend, append, remove and search
// commands.
// ---------------------------------------------------------------------------
// The engine takes one command word per clock and returns its result word on
// the next cycle from an output register; a new command is taken while a
// result waits, as long as the output register is free or being drained.
// Every command is decided combinationally: all CAPACITY cells compare against
// the command value at once, and the insert position is found by a one-bit
// claim signal rippling through the row, so the length of that chain and the
// search match reduction set the clock period. After reset the list is empty
// and ready at once; no clearing pass is needed.
module sorted_list_engine_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command [2:0], value [34:3], zero fill [39:35]
  input  logic [sle_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // status [1:0], result_value [33:2], found [34], length [39:35],
  // is_empty [40], zero fill [47:41]
  output logic [sle_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);
  import sle_pkg::*;

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW   = CountW + LengthW;

  // input word fields
  logic [CmdW-1:0]          in_cmd;
  logic signed [ValueW-1:0] in_value;
  logic                     accept;

  // cell row
  cell_ctrl_t               ctrl;
  logic signed [ValueW-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]      valids;
  logic [CAPACITY-1:0]      hit_bits;
  logic [CAPACITY:0]        claims;

  // list length
  logic [CountW-1:0] count_q, count_d;
  logic              full, empty;

  // result fields
  status_e                  status;
  logic signed [ValueW-1:0] res_value;
  logic                     found;
  logic [ExtW-1:0]          count_ext;

  // output register
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                out_valid_q;

  assign in_cmd   = s_axis_tdata_i[CmdW-1:0];
  assign in_value = s_axis_tdata_i[CmdW+ValueW-1:CmdW];

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  assign full  = (count_q == CountW'(CAPACITY));
  assign empty = (count_q == '0);

  // command decode and result
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.value = in_value;
    status     = ST_OK;
    res_value  = in_value;
    found      = 1'b0;
    count_d    = count_q;
    unique case (in_cmd)
      CMD_INSERT, CMD_PREPEND, CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_d = count_q + CountW'(1);
          if (in_cmd == CMD_INSERT) begin
            ctrl.op = OP_INSERT;
          end else if (in_cmd == CMD_PREPEND) begin
            ctrl.op = OP_PREPEND;
          end else begin
            ctrl.op = OP_APPEND;
          end
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status    = ST_EMPTY;
          res_value = '0;
        end else begin
          ctrl.op   = OP_REMOVE;
          res_value = entries[0];
          count_d   = count_q - CountW'(1);
        end
      end
      CMD_SEARCH: begin
        found = |hit_bits;
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
    if (!accept) begin
      ctrl.op = OP_HOLD;
      count_d = count_q;
    end
    count_ext  = ExtW'(count_d);
    out_data_d = '0;
    out_data_d[StatusW-1:0]               = status;
    out_data_d[StatusW+ValueW-1:StatusW]  = res_value;
    out_data_d[StatusW+ValueW]            = found;
    out_data_d[StatusW+ValueW+LengthW:StatusW+ValueW+1] = count_ext[LengthW-1:0];
    out_data_d[StatusW+ValueW+LengthW+1]  = (count_d == '0);
  end

  // row of cells
  assign claims[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] left_entry, right_entry;
    logic                     left_valid, right_valid;
    if (i == 0) begin : g_head
      assign left_entry = in_value;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_valid = valids[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_entry = entries[i+1];
      assign right_valid = valids[i+1];
    end
    sle_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_entry_i  (left_entry),
      .left_valid_i  (left_valid),
      .right_entry_i (right_entry),
      .right_valid_i (right_valid),
      .claim_i       (claims[i]),
      .claim_o       (claims[i+1]),
      .match_o       (hit_bits[i]),
      .entry_o       (entries[i]),
      .valid_o       (valids[i])
    );
  end

  // length and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

  // last claim output is only meaningful inside the row
  logic unused_claim;
  assign unused_claim = claims[CAPACITY];

endmodule

// ===== rtl/core/sle_cell.sv =====
// ---------------------------------------------------------------------------
// sle_cell
// One slot of the ordered list: holds an entry and its valid bit, compares
// against the broadcast value and shifts with its neighbors.
// ---------------------------------------------------------------------------
module sle_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sle_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [sle_pkg::ValueW-1:0] left_entry_i,
  input  logic                              left_valid_i,
  input  logic signed [sle_pkg::ValueW-1:0] right_entry_i,
  input  logic                              right_valid_i,
  input  logic                              claim_i,
  output logic                              claim_o,
  output logic                              match_o,
  output logic signed [sle_pkg::ValueW-1:0] entry_o,
  output logic                              valid_o
);
  import sle_pkg::*;

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     valid_q, valid_d;
  logic                     gt;

  // compare and next-slot selection
  always_comb begin
    gt      = valid_q && ($signed(entry_q) > $signed(ctrl_i.value));
    claim_o = claim_i | gt | ~valid_q;
    match_o = valid_q && (entry_q == ctrl_i.value);
    entry_d = entry_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        valid_d = valid_q | left_valid_i;
        if (claim_i) begin
          entry_d = left_entry_i;
        end else if (gt || !valid_q) begin
          entry_d = ctrl_i.value;
        end
      end
      OP_PREPEND: begin
        valid_d = valid_q | left_valid_i;
        entry_d = left_entry_i;
      end
      OP_APPEND: begin
        valid_d = valid_q | left_valid_i;
        if (!valid_q && left_valid_i) begin
          entry_d = ctrl_i.value;
        end
      end
      OP_REMOVE: begin
        valid_d = right_valid_i;
        entry_d = right_entry_i;
      end
      default: begin
        entry_d = entry_q;
        valid_d = valid_q;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/core/sle_checker.sv =====
// ---------------------------------------------------------------------------
// sle_checker
// Port-level checks for the sorted list engine, bound to the top level.
// ---------------------------------------------------------------------------
module sle_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic [sle_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [sle_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i
);
  import sle_pkg::*;

  logic [StatusW-1:0] st;
  logic [ValueW-1:0]  res;
  logic               fnd;
  logic [LengthW-1:0] len;
  logic               emp;

  assign st  = m_axis_tdata_o[StatusW-1:0];
  assign res = m_axis_tdata_o[StatusW+ValueW-1:StatusW];
  assign fnd = m_axis_tdata_o[StatusW+ValueW];
  assign len = m_axis_tdata_o[StatusW+ValueW+LengthW:StatusW+ValueW+1];
  assign emp = m_axis_tdata_o[StatusW+ValueW+LengthW+1];

  // an empty list reports zero length
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && emp |-> len == '0)
    else $error("empty flag with nonzero length");

  // a refused remove returns zero and an empty list
  a_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == ST_EMPTY |-> res == '0 && emp)
    else $error("empty status with bad result");

  // only successful commands on a non-empty list report a match, never a full list refusal
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && fnd |-> st == ST_OK && !emp)
    else $error("found flag on failed command or empty list");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

endmodule

bind sorted_list_engine_core sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

// ===== sim/tb_sorted_list_engine_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sorted_list_engine_core
// Stream-level test of the sorted list engine. A directed table covers the
// empty and full list, value extremes, equal values, every command and one
// spare command code. Random fill and drain traffic follows. Every result
// word is checked field by field against its table row or a queue model.
// ---------------------------------------------------------------------------
module tb_sorted_list_engine_core;
  import sle_pkg::*;

  localparam int unsigned Capacity    = 16;
  localparam int          NumDirected = 25;
  localparam int          NumRandom   = 1425;
  localparam int          StallLimit  = 4000;
  localparam int          HoldCycles  = 120;
  // command codes the engine ignores
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd5;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  // one result word split into its fields
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value;
    logic               found;
    logic [LengthW-1:0] length;
    logic               is_empty;
  } list_result_t;

  // one row of the directed table
  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
    logic              typed;
    list_result_t      want;
  } cmd_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;

  // expectation carried alongside the word being offered
  logic                row_typed = 1'b0;
  list_result_t        row_want = '0;

  // model of the list contents, head first
  logic [ValueW-1:0]   list_model[$];
  list_result_t        result_fifo[$];

  int idle_phase = 0;
  int words_in = 0;
  int words_out = 0;
  int mismatches = 0;
  int full_refusals = 0;
  int empty_removes = 0;
  int search_hits = 0;
  int spare_cmds = 0;
  int times_full = 0;
  int times_empty = 0;

  sorted_list_engine_core #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // reset held low at the start, then released
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic cmd_row_t stim_row(logic [CmdW-1:0] cmd, logic [ValueW-1:0] value,
                                        logic typed, logic [StatusW-1:0] st,
                                        logic [ValueW-1:0] rv, logic [LengthW-1:0] len);
    cmd_row_t r;
    r.cmd = cmd;
    r.value = value;
    r.typed = typed;
    r.want = '{status: st, value: rv, found: 1'b0, length: len, is_empty: (len == 0)};
    return r;
  endfunction

  // apply one command to the list model and return the result word
  function automatic list_result_t apply_list_cmd(logic [CmdW-1:0] cmd,
                                                  logic [ValueW-1:0] value);
    list_result_t r;
    int pos;
    r.status = ST_OK;
    r.value = value;
    r.found = 1'b0;
    case (cmd)
      CMD_INSERT, CMD_PREPEND, CMD_APPEND: begin
        if (list_model.size() >= Capacity) begin
          r.status = ST_FULL;
          full_refusals++;
        end else if (cmd == CMD_PREPEND) begin
          list_model.push_front(value);
        end else if (cmd == CMD_APPEND) begin
          list_model.push_back(value);
        end else begin
          // first stored value strictly larger, so equal values stay ahead
          pos = list_model.size();
          for (int i = list_model.size() - 1; i >= 0; i--) begin
            if ($signed(list_model[i]) > $signed(value)) pos = i;
          end
          list_model.insert(pos, value);
        end
        if (r.status == ST_OK && list_model.size() == Capacity) times_full++;
      end
      CMD_REMOVE: begin
        if (list_model.size() == 0) begin
          r.status = ST_EMPTY;
          r.value = '0;
          empty_removes++;
        end else begin
          r.value = list_model.pop_front();
          if (list_model.size() == 0) times_empty++;
        end
      end
      CMD_SEARCH: begin
        foreach (list_model[i]) begin
          if (list_model[i] == value) r.found = 1'b1;
        end
        if (r.found) search_hits++;
      end
      default: spare_cmds++;
    endcase
    r.length = LengthW'(list_model.size());
    r.is_empty = (list_model.size() == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [ValueW-1:0] got,
                                 logic [ValueW-1:0] want);
    $display("tb: result word %0d: %s is 0x%0h, expected 0x%0h",
             words_out, field, got, want);
    mismatches++;
  endtask

  // predict on every accepted command, check every accepted result
  always @(posedge clk_i) begin : monitor
    list_result_t predicted;
    list_result_t got;
    list_result_t want;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        predicted = apply_list_cmd(s_tdata[2:0], s_tdata[34:3]);
        result_fifo.push_back(row_typed ? row_want : predicted);
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.value = m_tdata[33:2];
        got.found = m_tdata[34];
        got.length = m_tdata[39:35];
        got.is_empty = m_tdata[40];
        if (result_fifo.size() == 0) begin
          $display("tb: result word %0d arrived with nothing expected", words_out);
          mismatches++;
        end else begin
          want = result_fifo.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.length !== want.length) report_mismatch("length", got.length, want.length);
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", got.is_empty, want.is_empty);
        end
        words_out++;
      end
    end
  end

  // result side: random stalls plus one long hold-off in the last phase
  initial begin : receiver
    int stall_left;
    int pct;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && idle_phase == 2 && words_in >= NumDirected + 2 * NumRandom / 3 + 40)
      begin
        stall_left = HoldCycles;
        hold_done = 1'b1;
      end
      pct = (idle_phase == 0) ? 78 : (idle_phase == 1) ? 35 : 0;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= pct);
      end
    end
  end

  // watchdog on cycles without any accepted word
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb: no word moved for %0d cycles", StallLimit);
    $display("tb_sorted_list_engine_core: FAIL");
    $finish;
  end

  // command side: directed table, then random fill and drain traffic
  initial begin : stimulus
    cmd_row_t          rows[NumDirected];
    logic [ValueW-1:0] boundary_vals[5];
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
    logic              typed;
    list_result_t      want;
    bit                draining;
    int                gap_pct;
    int                r;

    rows[0]  = stim_row(CMD_REMOVE,  32'h0000_0000, 1, ST_EMPTY, 32'h0000_0000, 0);
    rows[1]  = stim_row(CMD_SEARCH,  32'h7FFF_FFFF, 1, ST_OK,    32'h7FFF_FFFF, 0);
    rows[2]  = stim_row(CMD_INSERT,  32'h7FFF_FFFF, 1, ST_OK,    32'h7FFF_FFFF, 1);
    rows[3]  = stim_row(CMD_INSERT,  32'h8000_0000, 1, ST_OK,    32'h8000_0000, 2);
    rows[4]  = stim_row(CMD_INSERT,  32'h0000_0000, 1, ST_OK,    32'h0000_0000, 3);
    rows[5]  = stim_row(CMD_INSERT,  32'h0000_0000, 1, ST_OK,    32'h0000_0000, 4);
    rows[6]  = stim_row(CMD_PREPEND, 32'h7FFF_FFFF, 0, ST_OK, '0, 0);
    rows[7]  = stim_row(CMD_APPEND,  32'h8000_0000, 0, ST_OK, '0, 0);
    rows[8]  = stim_row(CMD_INSERT,  32'hFFFF_FFFF, 0, ST_OK, '0, 0);
    rows[9]  = stim_row(CMD_INSERT,  32'h0000_0001, 0, ST_OK, '0, 0);
    rows[10] = stim_row(CMD_APPEND,  32'h5555_5555, 0, ST_OK, '0, 0);
    rows[11] = stim_row(CMD_PREPEND, 32'hAAAA_AAAA, 0, ST_OK, '0, 0);
    rows[12] = stim_row(CMD_INSERT,  32'h0000_FFFF, 0, ST_OK, '0, 0);
    rows[13] = stim_row(CMD_INSERT,  32'hFFFF_0000, 0, ST_OK, '0, 0);
    rows[14] = stim_row(CMD_INSERT,  32'd100,       0, ST_OK, '0, 0);
    rows[15] = stim_row(CMD_INSERT,  32'd100,       0, ST_OK, '0, 0);
    rows[16] = stim_row(CMD_INSERT,  32'hFFFF_FF9C, 0, ST_OK, '0, 0);
    rows[17] = stim_row(CMD_INSERT,  32'd7,         0, ST_OK, '0, 0);
    // list is full now: all three adds are refused
    rows[18] = stim_row(CMD_INSERT,  32'd3,         1, ST_FULL,  32'd3,         16);
    rows[19] = stim_row(CMD_PREPEND, 32'h1234_5678, 1, ST_FULL,  32'h1234_5678, 16);
    rows[20] = stim_row(CMD_APPEND,  32'h8000_0000, 1, ST_FULL,  32'h8000_0000, 16);
    rows[21] = stim_row(CMD_SEARCH,  32'd100,       0, ST_OK, '0, 0);
    rows[22] = stim_row(CMD_SEARCH,  32'd101,       0, ST_OK, '0, 0);
    rows[23] = stim_row(CmdSpareLo,  32'hDEAD_BEEF, 1, ST_OK,    32'hDEAD_BEEF, 16);
    // remove ignores its value
    rows[24] = stim_row(CMD_REMOVE,  32'hFFFF_FFFF, 0, ST_OK, '0, 0);

    boundary_vals[0] = 32'h7FFF_FFFF;
    boundary_vals[1] = 32'h8000_0000;
    boundary_vals[2] = 32'h0000_0000;
    boundary_vals[3] = 32'hFFFF_FFFF;
    boundary_vals[4] = 32'h0000_0001;
    draining = 1'b0;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int n = 0; n < NumDirected + NumRandom; n++) begin
      idle_phase = (n < NumDirected + NumRandom / 3) ? 0 :
                   (n < NumDirected + 2 * NumRandom / 3) ? 1 : 2;
      if (n < NumDirected) begin
        cmd = rows[n].cmd;
        value = rows[n].value;
        typed = rows[n].typed;
        want = rows[n].want;
      end else begin
        typed = 1'b0;
        want = '0;
        // swing between filling and draining so both ends are reached often
        if (list_model.size() >= Capacity) draining = 1'b1;
        else if (list_model.size() == 0) draining = 1'b0;
        else if ($urandom_range(99) < 2) draining = !draining;
        r = $urandom_range(99);
        if (!draining) begin
          cmd = (r < 45) ? CMD_INSERT : (r < 57) ? CMD_PREPEND : (r < 69) ? CMD_APPEND :
                (r < 82) ? CMD_REMOVE : CMD_SEARCH;
        end else begin
          cmd = (r < 15) ? CMD_INSERT : (r < 20) ? CMD_PREPEND : (r < 25) ? CMD_APPEND :
                (r < 72) ? CMD_REMOVE : CMD_SEARCH;
        end
        if (r >= 97) cmd = CmdW'($urandom_range(CmdSpareHi, CmdSpareLo));
        // small values give ties and hits, stored values give search hits
        r = $urandom_range(99);
        if (r < 35) value = $urandom_range(16) - 8;
        else if (r < 45) value = boundary_vals[$urandom_range(4)];
        else if (r < 65 && list_model.size() > 0)
          value = list_model[$urandom_range(list_model.size() - 1)];
        else value = $urandom();
      end
      gap_pct = (idle_phase == 0) ? 35 : (idle_phase == 1) ? 78 : 0;
      while ($urandom_range(99) < gap_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {5'b0, value, cmd};
      row_typed <= typed;
      row_want <= want;
      do @(posedge clk_i); while (!s_tready);
    end
    s_tvalid <= 1'b0;
    row_typed <= 1'b0;

    // drain, then keep watching for stray words
    while (result_fifo.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (result_fifo.size() != 0) mismatches++;

    $display("tb: %0d commands, %0d results, %0d mismatches, list full %0d, empty %0d times",
             words_in, words_out, mismatches, times_full, times_empty);
    $display("tb: %0d refused adds, %0d empty removes, %0d search hits, %0d spare codes",
             full_refusals, empty_removes, search_hits, spare_cmds);
    if (mismatches == 0) begin
      $display("tb_sorted_list_engine_core: PASS");
    end else begin
      $display("tb_sorted_list_engine_core: FAIL");
    end
    $finish;
  end

endmodule
